// ===== src/lesp_pkg.sv =====
package lesp_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_SIGMA_GAIN    = 3'd0;
   localparam logic [2:0] CSR_RHO_GAIN      = 3'd1;
   localparam logic [2:0] CSR_BETA_GAIN     = 3'd2;
   localparam logic [2:0] CSR_TIME_STEP     = 3'd3;
   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd5;
   localparam logic [2:0] CSR_PLOT_SCALE    = 3'd6;

   // Register reset values
   localparam logic [30:0] SIGMA_RESET  = 31'd655360;
   localparam logic [30:0] RHO_RESET    = 31'd1835008;
   localparam logic [30:0] BETA_RESET   = 31'd174763;
   localparam logic [16:0] DT_RESET     = 17'd655;
   localparam logic [12:0] WIDTH_RESET  = 13'd1920;
   localparam logic [12:0] HEIGHT_RESET = 13'd1080;
   localparam logic [23:0] SCALE_RESET  = 24'd675021;

   // Input item kinds
   localparam logic OP_STEP = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // Width of the product and of all intermediate sums
   localparam int WIDE = 66;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OPS,
      ST_MUL,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Multiplication steps, in the order the sequencer runs them
   typedef enum logic [3:0] {
      SP_SIGMA_DIFF,
      SP_DX,
      SP_RHO,
      SP_DY,
      SP_XY,
      SP_BETA,
      SP_DZ,
      SP_PIX_COL,
      SP_PIX_ROW
   } step_type;

   typedef struct packed {
      logic req_ready;
      logic ops_load;
      logic mul_en;
      logic upd_en;
      logic finish_en;
   } ctrl_type;

   typedef struct packed {
      logic        valid;
      logic [11:0] pix;
   } pixel_type;

   function automatic logic signed [31:0] sat32(input logic signed [WIDE-1:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== src/lorenz_euler_step_plotter.sv =====
// Channel  | Direction | Payload
// req_     | in        | tuser: operation, trajectory; tdata: load_x, load_y, load_z
// rsp_     | out       | tuser: out_trajectory, pixel_valid; tdata: new_x .. pixel_row
// csr_     | in        | write enable, register index, write data
//
// One shared 33 x 33 signed multiplier forms each product through an operand
// load and a product register. A step item takes nine products, an update state
// and a finish state; a load item takes two pixel products. A new item is taken
// only once the previous result is in the output register.
// Reset is synchronous and restores registers and trajectory state. A stalled
// result waits in the output register and holds the next item in its finish state.
module lorenz_euler_step_plotter #(
   parameter int FRAC_BITS        = 16,
   parameter int TRAJECTORY_COUNT = 2
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // load_x, load_y, load_z
   input  logic [1:0]   req_tuser,   // operation, trajectory

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // new_x, new_y, new_z, pixel_col, pixel_row
   output logic [1:0]   rsp_tuser,   // out_trajectory, pixel_valid

   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [30:0]  csr_wdata
);

   localparam int IDX_W = (TRAJECTORY_COUNT > 1) ? $clog2(TRAJECTORY_COUNT) : 1;
   localparam int W     = lesp_pkg::WIDE;

   // Configuration registers
   logic [30:0] sigma_ff, rho_ff, beta_ff;
   logic [16:0] dt_ff;
   logic [12:0] width_ff, height_ff;
   logic [23:0] scale_ff;

   // Trajectory state
   logic signed [31:0] pos_x_ff [TRAJECTORY_COUNT];
   logic signed [31:0] pos_y_ff [TRAJECTORY_COUNT];
   logic signed [31:0] pos_z_ff [TRAJECTORY_COUNT];

   lesp_pkg::state_type state_ff, state_in;
   lesp_pkg::step_type  step_ff, step_in;
   lesp_pkg::ctrl_type  ctrl;

   logic [IDX_W-1:0]   idx_ff, req_idx;
   logic               traj_ff, req_traj;
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic signed [31:0] nx_ff, ny_ff, nz_ff;
   logic signed [31:0] dx_ff, dy_ff, a_ff;
   logic signed [32:0] opa_ff, opa_in, opb_ff, opb_in;
   logic signed [W-1:0] prod_ff, mul_res;
   logic signed [31:0] fx_res;
   lesp_pkg::pixel_type col_ff, col_res, row_res;

   logic         out_free;
   logic         accept;
   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [119:0] rsp_tdata_ff;
   logic [1:0]   rsp_tuser_ff;

   function automatic logic signed [W-1:0] ext32(input logic signed [31:0] v);
      return W'(v);
   endfunction

   // Clamp to plus or minus size in fixed point, then saturate.
   function automatic logic signed [31:0] clamp_sym(input logic signed [W-1:0] v,
                                                    input logic [12:0] size);
      logic signed [W-1:0] bound;
      logic signed [W-1:0] r;
      bound = $signed({{(W-13){1'b0}}, size}) <<< FRAC_BITS;
      r = v;
      if (r > bound) r = bound;
      if (r < -bound) r = -bound;
      return lesp_pkg::sat32(r);
   endfunction

   // Pixel from the product coordinate times scale.
   function automatic lesp_pkg::pixel_type to_pixel(input logic signed [W-1:0] prod,
                                                    input logic [12:0] size);
      logic signed [W-1:0] p;
      logic signed [W-1:0] bound;
      lesp_pkg::pixel_type r;
      bound   = $signed({{(W-13){1'b0}}, size}) <<< FRAC_BITS;
      p       = (prod >>> FRAC_BITS) + ($signed({{(W-13){1'b0}}, size}) <<< (FRAC_BITS - 1));
      r.valid = (p >= 0) && (p < bound);
      r.pix   = r.valid ? p[FRAC_BITS +: 12] : 12'd0;
      return r;
   endfunction

   assign accept   = req_tvalid && ctrl.req_ready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign mul_res  = opa_ff * opb_ff;
   assign fx_res   = lesp_pkg::sat32(prod_ff >>> FRAC_BITS);
   assign col_res  = to_pixel(prod_ff, width_ff);
   assign row_res  = to_pixel(prod_ff, height_ff);

   always_comb begin
      req_traj = (TRAJECTORY_COUNT > 1) ? req_tuser[1] : 1'b0;
      req_idx  = IDX_W'(req_traj);
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff  <= lesp_pkg::SIGMA_RESET;
         rho_ff    <= lesp_pkg::RHO_RESET;
         beta_ff   <= lesp_pkg::BETA_RESET;
         dt_ff     <= lesp_pkg::DT_RESET;
         width_ff  <= lesp_pkg::WIDTH_RESET;
         height_ff <= lesp_pkg::HEIGHT_RESET;
         scale_ff  <= lesp_pkg::SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lesp_pkg::CSR_SIGMA_GAIN:    sigma_ff  <= csr_wdata;
            lesp_pkg::CSR_RHO_GAIN:      rho_ff    <= csr_wdata;
            lesp_pkg::CSR_BETA_GAIN:     beta_ff   <= csr_wdata;
            lesp_pkg::CSR_TIME_STEP:     dt_ff     <= csr_wdata[16:0];
            lesp_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata[12:0];
            lesp_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wdata[12:0];
            lesp_pkg::CSR_PLOT_SCALE:    scale_ff  <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // Trajectory state, written once per item when the result is issued
   for (genvar g = 0; g < TRAJECTORY_COUNT; g++) begin : g_traj
      localparam logic signed [31:0] RST_X =
         32'((((64'(g) + 64'd1) << FRAC_BITS) + 64'd5) / 64'd10);
      always_ff @(posedge clock) begin
         if (reset) begin
            pos_x_ff[g] <= RST_X;
            pos_y_ff[g] <= '0;
            pos_z_ff[g] <= '0;
         end else if (ctrl.finish_en && idx_ff == IDX_W'(g)) begin
            pos_x_ff[g] <= nx_ff;
            pos_y_ff[g] <= ny_ff;
            pos_z_ff[g] <= nz_ff;
         end
      end
   end

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         lesp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = lesp_pkg::ST_OPS;
               step_in  = (req_tuser[0] == lesp_pkg::OP_LOAD) ?
                          lesp_pkg::SP_PIX_COL : lesp_pkg::SP_SIGMA_DIFF;
            end
         end
         lesp_pkg::ST_OPS: state_in = lesp_pkg::ST_MUL;
         lesp_pkg::ST_MUL: begin
            case (step_ff)
               lesp_pkg::SP_SIGMA_DIFF: begin
                  step_in = lesp_pkg::SP_DX;   state_in = lesp_pkg::ST_OPS;
               end
               lesp_pkg::SP_DX: begin
                  step_in = lesp_pkg::SP_RHO;  state_in = lesp_pkg::ST_OPS;
               end
               lesp_pkg::SP_RHO: begin
                  step_in = lesp_pkg::SP_DY;   state_in = lesp_pkg::ST_OPS;
               end
               lesp_pkg::SP_DY: begin
                  step_in = lesp_pkg::SP_XY;   state_in = lesp_pkg::ST_OPS;
               end
               lesp_pkg::SP_XY: begin
                  step_in = lesp_pkg::SP_BETA; state_in = lesp_pkg::ST_OPS;
               end
               lesp_pkg::SP_BETA: begin
                  step_in = lesp_pkg::SP_DZ;   state_in = lesp_pkg::ST_OPS;
               end
               lesp_pkg::SP_DZ: state_in = lesp_pkg::ST_UPDATE;
               lesp_pkg::SP_PIX_COL: begin
                  step_in = lesp_pkg::SP_PIX_ROW; state_in = lesp_pkg::ST_OPS;
               end
               default: state_in = lesp_pkg::ST_FINISH;
            endcase
         end
         lesp_pkg::ST_UPDATE: begin
            step_in  = lesp_pkg::SP_PIX_COL;
            state_in = lesp_pkg::ST_OPS;
         end
         lesp_pkg::ST_FINISH: begin
            if (out_free) state_in = lesp_pkg::ST_IDLE;
         end
         default: state_in = lesp_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: control outputs
   always_comb begin
      ctrl           = '0;
      ctrl.req_ready = (state_ff == lesp_pkg::ST_IDLE);
      ctrl.ops_load  = (state_ff == lesp_pkg::ST_OPS);
      ctrl.mul_en    = (state_ff == lesp_pkg::ST_MUL);
      ctrl.upd_en    = (state_ff == lesp_pkg::ST_UPDATE);
      ctrl.finish_en = (state_ff == lesp_pkg::ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lesp_pkg::ST_IDLE;
         step_ff  <= lesp_pkg::SP_SIGMA_DIFF;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Operand selection for the shared multiplier
   always_comb begin
      opa_in = opa_ff;
      opb_in = opb_ff;
      case (step_ff)
         lesp_pkg::SP_SIGMA_DIFF: begin
            opa_in = $signed({2'b00, sigma_ff});
            opb_in = 33'(lesp_pkg::sat32(ext32(y_ff) - ext32(x_ff)));
         end
         lesp_pkg::SP_DX: begin
            opa_in = 33'(fx_res);
            opb_in = $signed({16'd0, dt_ff});
         end
         lesp_pkg::SP_RHO: begin
            opa_in = 33'(x_ff);
            opb_in = 33'(lesp_pkg::sat32($signed({{(W-31){1'b0}}, rho_ff}) - ext32(z_ff)));
         end
         lesp_pkg::SP_DY: begin
            opa_in = 33'(lesp_pkg::sat32(ext32(fx_res) - ext32(y_ff)));
            opb_in = $signed({16'd0, dt_ff});
         end
         lesp_pkg::SP_XY: begin
            opa_in = 33'(x_ff);
            opb_in = 33'(y_ff);
         end
         lesp_pkg::SP_BETA: begin
            opa_in = $signed({2'b00, beta_ff});
            opb_in = 33'(z_ff);
         end
         lesp_pkg::SP_DZ: begin
            opa_in = 33'(lesp_pkg::sat32(ext32(a_ff) - ext32(fx_res)));
            opb_in = $signed({16'd0, dt_ff});
         end
         lesp_pkg::SP_PIX_COL: begin
            opa_in = 33'(nx_ff);
            opb_in = $signed({9'd0, scale_ff});
         end
         lesp_pkg::SP_PIX_ROW: begin
            opa_in = 33'(ny_ff);
            opb_in = $signed({9'd0, scale_ff});
         end
         default: ;
      endcase
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff  <= req_idx;
         traj_ff <= req_traj;
         x_ff    <= pos_x_ff[req_idx];
         y_ff    <= pos_y_ff[req_idx];
         z_ff    <= pos_z_ff[req_idx];
         if (req_tuser[0] == lesp_pkg::OP_LOAD) begin
            nx_ff <= req_tdata[31:0];
            ny_ff <= req_tdata[63:32];
            nz_ff <= req_tdata[95:64];
         end
      end
      if (ctrl.ops_load) begin
         opa_ff <= opa_in;
         opb_ff <= opb_in;
         // Results of the previous multiplication that later steps need
         case (step_ff)
            lesp_pkg::SP_RHO:     dx_ff  <= fx_res;
            lesp_pkg::SP_XY:      dy_ff  <= fx_res;
            lesp_pkg::SP_BETA:    a_ff   <= fx_res;
            lesp_pkg::SP_PIX_ROW: col_ff <= col_res;
            default: ;
         endcase
      end
      if (ctrl.mul_en) begin
         prod_ff <= mul_res;
      end
      if (ctrl.upd_en) begin
         nx_ff <= clamp_sym(ext32(x_ff) + ext32(dx_ff), width_ff);
         ny_ff <= clamp_sym(ext32(y_ff) + ext32(dy_ff), height_ff);
         nz_ff <= lesp_pkg::sat32(ext32(z_ff) + ext32(fx_res));
      end
   end

   // Output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (ctrl.finish_en) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish_en) begin
         if (col_ff.valid && row_res.valid) begin
            rsp_tdata_ff <= {row_res.pix, col_ff.pix, nz_ff, ny_ff, nx_ff};
            rsp_tuser_ff <= {1'b1, traj_ff};
         end else begin
            rsp_tdata_ff <= {24'd0, nz_ff, ny_ff, nx_ff};
            rsp_tuser_ff <= {1'b0, traj_ff};
         end
      end
   end

   assign req_tready = ctrl.req_ready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // An off-screen point reports a zero pixel position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[119:96] == 24'd0)
      else $error("off-screen result carries a nonzero pixel");

   // The state of trajectory 0 only changes when a result is issued.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != lesp_pkg::ST_FINISH) |=>
         $stable(pos_x_ff[0]) && $stable(pos_y_ff[0]) && $stable(pos_z_ff[0]))
      else $error("trajectory state changed outside result issue");

   // A new result only appears out of the finishing state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == lesp_pkg::ST_FINISH))
      else $error("result raised without a finished item");

   // No item is taken while the sequencer is busy.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lesp_pkg::ST_MUL || state_ff == lesp_pkg::ST_UPDATE) |-> !req_tready)
      else $error("input ready while sequencer busy");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int FRAC        = 16;
   localparam int ONE         = 1 << FRAC;
   localparam int LONG_HOLD   = 400;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 40;
   localparam int PRINT_LIMIT = 50;

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -WORD_MAX - 1;

   typedef struct packed {
      logic        traj;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [11:0] col;
      logic [11:0] row;
      logic        on_screen;
   } plot_point_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_PERIODIC,
      RX_BURSTY
   } rx_pattern_type;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata  = '0;   // load_x, load_y, load_z
   logic [1:0]   req_tuser  = '0;   // operation, trajectory
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;         // new_x, new_y, new_z, pixel_col, pixel_row
   logic [1:0]   rsp_tuser;         // out_trajectory, pixel_valid
   logic         csr_we     = 1'b0;
   logic [2:0]   csr_index  = lesp_pkg::CSR_SIGMA_GAIN;
   logic [30:0]  csr_wdata  = '0;

   // Predicted trajectory state and register copies
   longint pos_x [2];
   longint pos_y [2];
   longint pos_z [2];
   longint sigma_q, rho_q, beta_q, dt_q, width_px, height_px, scale_q;

   plot_point_type expected_points [$];
   plot_point_type arrived_point;

   int             fail_count    = 0;
   int             quiet_cycles  = 0;
   int             burst_left    = 0;
   int             gap_max       = 0;
   int             hold_requests = 0;
   int             holds_done    = 0;
   int             hold_left     = 0;
   int             stall_left    = 0;
   int             rx_cycle      = 0;
   rx_pattern_type rx_pattern    = RX_ALWAYS;

   lorenz_euler_step_plotter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint sat_word(input longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // Arithmetic shift gives the floor of the scaled product.
   function automatic longint fx_product(input longint a, input longint b);
      return sat_word((a * b) >>> FRAC);
   endfunction

   function automatic longint clamp_to_screen(input longint v, input longint size_px);
      longint bound;
      bound = size_px <<< FRAC;
      if (v > bound) v = bound;
      if (v < -bound) v = -bound;
      return sat_word(v);
   endfunction

   function automatic logic pixel_of(input longint c, input longint size_px,
                                     output logic [11:0] pix);
      longint p;
      longint q;
      p = ((c * scale_q) >>> FRAC) + (size_px <<< (FRAC - 1));
      q = p >>> FRAC;
      pix = q[11:0];
      return (p >= 0) && (p < (size_px <<< FRAC));
   endfunction

   function automatic plot_point_type predict_plot_point(input logic op, input logic traj,
                                                         input logic [31:0] lx,
                                                         input logic [31:0] ly,
                                                         input logic [31:0] lz);
      longint         x, y, z, nx, ny, nz, dx, dy, dz, prod_a, prod_b;
      logic [11:0]    col, row;
      logic           col_ok, row_ok;
      plot_point_type pt;
      x = pos_x[traj];
      y = pos_y[traj];
      z = pos_z[traj];
      if (op == lesp_pkg::OP_LOAD) begin
         nx = $signed(lx);
         ny = $signed(ly);
         nz = $signed(lz);
      end else begin
         // Every delta is taken from the state before this step.
         prod_a = fx_product(sigma_q, sat_word(y - x));
         dx     = fx_product(prod_a, dt_q);
         prod_a = fx_product(x, sat_word(rho_q - z));
         dy     = fx_product(sat_word(prod_a - y), dt_q);
         prod_a = fx_product(x, y);
         prod_b = fx_product(beta_q, z);
         dz     = fx_product(sat_word(prod_a - prod_b), dt_q);
         nx = clamp_to_screen(x + dx, width_px);
         ny = clamp_to_screen(y + dy, height_px);
         nz = sat_word(z + dz);
      end
      pos_x[traj] = nx;
      pos_y[traj] = ny;
      pos_z[traj] = nz;
      col_ok = pixel_of(nx, width_px, col);
      row_ok = pixel_of(ny, height_px, row);
      pt.traj      = traj;
      pt.x         = nx[31:0];
      pt.y         = ny[31:0];
      pt.z         = nz[31:0];
      pt.on_screen = col_ok && row_ok;
      pt.col       = pt.on_screen ? col : 12'd0;
      pt.row       = pt.on_screen ? row : 12'd0;
      return pt;
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   // Receiver: checks each result transfer and stalls on its own pattern.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_points.size() == 0) begin
            report_mismatch("result transfer with no item outstanding");
         end else begin
            arrived_point = expected_points.pop_front();
            check_field("out_trajectory", rsp_tuser[0], arrived_point.traj);
            check_field("pixel_valid", rsp_tuser[1], arrived_point.on_screen);
            check_field("new_x", rsp_tdata[31:0], arrived_point.x);
            check_field("new_y", rsp_tdata[63:32], arrived_point.y);
            check_field("new_z", rsp_tdata[95:64], arrived_point.z);
            check_field("pixel_col", rsp_tdata[107:96], arrived_point.col);
            check_field("pixel_row", rsp_tdata[119:108], arrived_point.row);
         end
      end
      rx_cycle++;
      if (hold_requests != holds_done) begin
         holds_done = hold_requests;
         hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_pattern)
            RX_ALWAYS:   rsp_tready <= 1'b1;
            RX_COIN:     rsp_tready <= ($urandom_range(99, 0) < 60);
            RX_PERIODIC: rsp_tready <= ((rx_cycle % 9) < 5);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
                  if ($urandom_range(15, 0) == 0) stall_left = $urandom_range(30, 1);
               end
            end
         endcase
      end
   end

   // Ends the run if neither side moves a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_item(input logic op, input logic traj, input logic [31:0] lx,
                            input logic [31:0] ly, input logic [31:0] lz);
      if (burst_left == 0) begin
         if (gap_max > 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(gap_max, 1)) @(posedge clock);
         end
         burst_left = $urandom_range(16, 1);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {lz, ly, lx};
      req_tuser  <= {traj, op};
      do @(posedge clock); while (req_tready !== 1'b1);
      expected_points.push_back(predict_plot_point(op, traj, lx, ly, lz));
   endtask

   task automatic drain_results;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_points.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [30:0] sigma, input logic [30:0] rho,
                                 input logic [30:0] beta, input logic [30:0] dt,
                                 input logic [30:0] w, input logic [30:0] h,
                                 input logic [30:0] scale);
      logic [2:0]  reg_idx;
      logic [30:0] value;
      drain_results();
      for (int k = int'(lesp_pkg::CSR_SIGMA_GAIN); k <= int'(lesp_pkg::CSR_PLOT_SCALE);
           k++) begin
         reg_idx = 3'(k);
         value   = '0;
         case (reg_idx)
            lesp_pkg::CSR_SIGMA_GAIN: begin
               value   = sigma;
               sigma_q = value;
            end
            lesp_pkg::CSR_RHO_GAIN: begin
               value = rho;
               rho_q = value;
            end
            lesp_pkg::CSR_BETA_GAIN: begin
               value  = beta;
               beta_q = value;
            end
            lesp_pkg::CSR_TIME_STEP: begin
               value = dt;
               dt_q  = value[16:0];
            end
            lesp_pkg::CSR_SCREEN_WIDTH: begin
               value    = w;
               width_px = value[12:0];
            end
            lesp_pkg::CSR_SCREEN_HEIGHT: begin
               value     = h;
               height_px = value[12:0];
            end
            lesp_pkg::CSR_PLOT_SCALE: begin
               value   = scale;
               scale_q = value[23:0];
            end
            default: ;
         endcase
         csr_we    <= 1'b1;
         csr_index <= reg_idx;
         csr_wdata <= value;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Mostly steps so the trajectories evolve; loads are mostly near the attractor.
   task automatic send_random_item;
      logic        op, traj;
      logic [31:0] lx, ly, lz;
      traj = $urandom_range(1, 0);
      op   = ($urandom_range(99, 0) < 12) ? lesp_pkg::OP_LOAD : lesp_pkg::OP_STEP;
      lx   = $urandom;
      ly   = $urandom;
      lz   = $urandom;
      if (op == lesp_pkg::OP_LOAD && $urandom_range(9, 0) < 7) begin
         lx = $urandom_range(80 * ONE, 0) - 40 * ONE;
         ly = $urandom_range(80 * ONE, 0) - 40 * ONE;
         lz = $urandom_range(60 * ONE, 0);
      end
      send_item(op, traj, lx, ly, lz);
   endtask

   task automatic run_random(input int count);
      repeat (count) begin
         if ($urandom_range(63, 0) == 0) begin
            case ($urandom_range(3, 0))
               0:       gap_max = 0;
               1:       gap_max = 2;
               2:       gap_max = 8;
               default: gap_max = 30;
            endcase
            rx_pattern = rx_pattern_type'($urandom_range(3, 0));
         end
         send_random_item();
      end
   endtask

   task automatic test_directed;
      gap_max    = 2;
      rx_pattern = RX_COIN;
      // The first steps start from the reset state of both trajectories.
      send_item(lesp_pkg::OP_STEP, 1'b0, '0, '0, '0);
      send_item(lesp_pkg::OP_STEP, 1'b1, '1, '1, '1);
      send_item(lesp_pkg::OP_LOAD, 1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_item(lesp_pkg::OP_STEP, 1'b0, '0, '0, '0);
      send_item(lesp_pkg::OP_LOAD, 1'b1, 32'h80000000, 32'h80000000, 32'h80000000);
      send_item(lesp_pkg::OP_STEP, 1'b1, '0, '0, '0);
      send_item(lesp_pkg::OP_LOAD, 1'b0, '0, '0, '0);
      send_item(lesp_pkg::OP_STEP, 1'b0, '0, '0, '0);
      send_item(lesp_pkg::OP_LOAD, 1'b1, ONE, ONE, ONE);
      repeat (2) send_item(lesp_pkg::OP_STEP, 1'b1, '0, '0, '0);
      // Column just outside both screen edges.
      send_item(lesp_pkg::OP_LOAD, 1'b0, 32'd6108266, '0, '0);
      send_item(lesp_pkg::OP_LOAD, 1'b0, 32'd6108267, '0, '0);
      send_item(lesp_pkg::OP_LOAD, 1'b0, -32'sd6108266, '0, '0);
      send_item(lesp_pkg::OP_LOAD, 1'b0, -32'sd6108267, '0, '0);
      // A load beyond the screen is kept as given; the next step clamps it.
      send_item(lesp_pkg::OP_LOAD, 1'b1, 3000 * ONE, -2000 * ONE, 40 * ONE);
      send_item(lesp_pkg::OP_STEP, 1'b1, '0, '0, '0);
      send_item(lesp_pkg::OP_LOAD, 1'b0, $urandom, $urandom, $urandom);
      send_item(lesp_pkg::OP_STEP, 1'b0, $urandom, $urandom, $urandom);
   endtask

   task automatic test_default_random;
      run_random(300);
   endtask

   task automatic test_random_settings;
      repeat (3) begin
         apply_settings($urandom_range(20 * ONE, 0), $urandom_range(50 * ONE, 0),
                        $urandom_range(5 * ONE, 0), $urandom_range(3277, 0),
                        $urandom_range(4096, 1), $urandom_range(4096, 1),
                        $urandom_range(40 * ONE, 0));
         run_random(150);
      end
   endtask

   task automatic test_saturating_settings;
      apply_settings(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h1FFFF,
                     31'h1FFF, 31'h1FFF, 31'hFFFFFF);
      run_random(150);
   endtask

   // A zero screen size leaves no pixel on screen and clamps to zero.
   task automatic test_zero_settings;
      apply_settings('0, '0, '0, '0, '0, '0, '0);
      run_random(80);
   endtask

   task automatic test_tiny_screen;
      apply_settings(lesp_pkg::SIGMA_RESET, lesp_pkg::RHO_RESET, lesp_pkg::BETA_RESET,
                     ONE, 31'd1, 31'd1, ONE);
      run_random(120);
   endtask

   task automatic test_full_screen;
      apply_settings(lesp_pkg::SIGMA_RESET, lesp_pkg::RHO_RESET, lesp_pkg::BETA_RESET,
                     31'd2000, 31'd4096, 31'd4096, ONE);
      run_random(100);
   endtask

   // The receiver holds off while the sender keeps offering items.
   task automatic test_output_stall;
      apply_settings(lesp_pkg::SIGMA_RESET, lesp_pkg::RHO_RESET, lesp_pkg::BETA_RESET,
                     lesp_pkg::DT_RESET, lesp_pkg::WIDTH_RESET, lesp_pkg::HEIGHT_RESET,
                     lesp_pkg::SCALE_RESET);
      gap_max    = 0;
      rx_pattern = RX_ALWAYS;
      hold_requests <= hold_requests + 1;
      run_random(150);
      gap_max    = 0;
      rx_pattern = RX_ALWAYS;
      hold_requests <= hold_requests + 1;
      run_random(150);
   endtask

   initial begin
      sigma_q   = lesp_pkg::SIGMA_RESET;
      rho_q     = lesp_pkg::RHO_RESET;
      beta_q    = lesp_pkg::BETA_RESET;
      dt_q      = lesp_pkg::DT_RESET;
      width_px  = lesp_pkg::WIDTH_RESET;
      height_px = lesp_pkg::HEIGHT_RESET;
      scale_q   = lesp_pkg::SCALE_RESET;
      for (int t = 0; t < 2; t++) begin
         pos_x[t] = ((longint'(t + 1) << FRAC) + 5) / 10;
         pos_y[t] = 0;
         pos_z[t] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_default_random();
      test_random_settings();
      test_saturating_settings();
      test_zero_settings();
      test_tiny_screen();
      test_full_screen();
      test_output_stall();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_points.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_points.size()));
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/lesp_pkg.sv
src/lorenz_euler_step_plotter.sv
sim/testbench.sv
